// ===== design/ppmfe_pkg.sv =====
// ============================================================================
// PPM frame encoder package
// Shared constants, configuration register codes and the request format
// that passes from the front part to the back part.
// ============================================================================
package ppmfe_pkg;

    // Fixed timing constants of the encoder.
    localparam int TICKS_PER_US = 2;
    localparam int INPUT_SHIFT  = 1;
    localparam int CENTER_US    = 1500;
    localparam int MAX_CHANNELS = 16;

    // Field widths.
    localparam int CH_W       = 13;
    localparam int TICK_W     = 16;
    localparam int ACC_W      = 18;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Channel width and frame arithmetic in ticks, and channel count limits.
    localparam logic signed [14:0] CENTER_TICKS = 15'(CENTER_US * TICKS_PER_US);
    localparam logic signed [14:0] RANGE_STD    = 15'(512 * 2);
    localparam logic signed [14:0] RANGE_EXT    = 15'(640 * 2);
    localparam logic [TICK_W-1:0]  SYNC_STEP    = 16'(50 * TICKS_PER_US);
    localparam logic [TICK_W-1:0]  SYNC_BASE    = 16'(300 * TICKS_PER_US);
    localparam logic [ACC_W-1:0]   FRAME_BASE   = 18'(22500 * TICKS_PER_US);
    localparam logic [ACC_W-1:0]   FRAME_STEP   = 18'(1000 * TICKS_PER_US);
    localparam logic [ACC_W-1:0]   REST_MIN     = 18'(9000);
    localparam logic [ACC_W-1:0]   REST_MAX     = 18'(65535);
    localparam logic [IDX_W-1:0]   COUNT_MAX    = 5'(MAX_CHANNELS);
    localparam logic [IDX_W-1:0]   COUNT_RESET  = 5'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_RANGE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_EXTRA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL    = 3'd4;

    // Configuration register set.
    typedef struct packed {
        logic       ext_range;
        logic [3:0] sync_delay;
        logic [3:0] frame_extra;
        logic [4:0] channel_count;
        logic       idle_level;
    } t_cfg;

    // One channel request: the intervals it produces, already computed.
    typedef struct packed {
        logic [TICK_W-1:0] sync_ticks;
        logic [TICK_W-1:0] rem_ticks;
        logic [TICK_W-1:0] rest_ticks;
        logic              last;
        logic              idle;
    } t_cmd;

endpackage

// ===== design/ppmfe_in_if.sv =====
// ============================================================================
// PPM frame encoder input channel
// Valid/ready channel that carries one signed channel value per request.
// ============================================================================
interface ppmfe_in_if;
    import ppmfe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CH_W-1:0] channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink   (input valid, input channel_value, output ready);
endinterface

// ===== design/ppmfe_out_if.sv =====
// ============================================================================
// PPM frame encoder output channel
// Valid/ready channel that carries one timed pin interval per request.
// ============================================================================
interface ppmfe_out_if;
    import ppmfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] interval_ticks;
    logic              pin_level;
    logic              frame_end;

    modport source (output valid, output interval_ticks, output pin_level,
                    output frame_end, input ready);
    modport sink   (input valid, input interval_ticks, input pin_level,
                    input frame_end, output ready);
endinterface

// ===== design/ppmfe_front.sv =====
// ============================================================================
// PPM frame encoder front part
// Accepts channel values, computes channel width, sync and remainder, keeps
// the frame position and the unused frame length, and emits one request.
// ============================================================================
module ppmfe_front import ppmfe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [CH_W-1:0] i_channel_value,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic [IDX_W-1:0]   r_index, n_index;
    logic [ACC_W-1:0]   r_acc, n_acc;

    logic signed [14:0] ch_shift;
    logic signed [14:0] ch_clamp;
    logic signed [14:0] lim;
    logic signed [14:0] width_s;
    logic [13:0]        width;
    logic [TICK_W-1:0]  sync_q;
    logic [TICK_W-1:0]  rem_q;
    logic [TICK_W-1:0]  rest_q;
    logic [TICK_W-1:0]  width16;
    logic [ACC_W-1:0]   width18;
    logic [ACC_W-1:0]   acc_base;
    logic [ACC_W-1:0]   acc_in;
    logic [IDX_W-1:0]   count_eff;
    logic               last;

    // The queue sets the pace of the input side.
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Shift, clamp and center the channel value.
    always_comb begin
        ch_shift = $signed({{2{i_channel_value[CH_W-1]}}, i_channel_value}) >>> INPUT_SHIFT;
        lim      = i_cfg.ext_range ? RANGE_EXT : RANGE_STD;
        ch_clamp = ch_shift;
        if (ch_shift < -lim) begin
            ch_clamp = -lim;
        end
        if (ch_shift > lim) begin
            ch_clamp = lim;
        end
        width_s = ch_clamp + CENTER_TICKS;
        width   = width_s[14] ? 14'd0 : width_s[13:0];
        width16 = 16'(width);
        width18 = 18'(width);
    end

    // Sync pulse length and the remainder of the channel slot.
    always_comb begin
        sync_q = 16'(i_cfg.sync_delay) * SYNC_STEP + SYNC_BASE;
        rem_q  = (width16 > sync_q) ? width16 - sync_q : '0;
    end

    // Frame position and unused frame length.
    always_comb begin
        acc_base = FRAME_BASE + 18'(i_cfg.frame_extra) * FRAME_STEP;
        acc_in   = (r_index == '0) ? acc_base : r_acc;
        n_acc    = (acc_in > width18) ? acc_in - width18 : '0;

        if (i_cfg.channel_count == '0) begin
            count_eff = 5'd1;
        end else if (i_cfg.channel_count > COUNT_MAX) begin
            count_eff = COUNT_MAX;
        end else begin
            count_eff = i_cfg.channel_count;
        end

        last    = ({1'b0, r_index} + 6'd1) >= {1'b0, count_eff};
        n_index = last ? '0 : r_index + 5'd1;

        if (n_acc < REST_MIN) begin
            rest_q = REST_MIN[TICK_W-1:0];
        end else if (n_acc > REST_MAX) begin
            rest_q = REST_MAX[TICK_W-1:0];
        end else begin
            rest_q = n_acc[TICK_W-1:0];
        end
    end

    // Request handed to the queue.
    assign o_cmd = '{sync_ticks: sync_q, rem_ticks: rem_q, rest_ticks: rest_q,
                     last: last, idle: i_cfg.idle_level};

    // State advances with each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_acc   <= '0;
        end else if (o_push) begin
            r_index <= n_index;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== design/ppmfe_queue.sv =====
// ============================================================================
// PPM frame encoder request queue
// Short first-in first-out queue that decouples the front and back parts.
// ============================================================================
module ppmfe_queue import ppmfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage needs no reset; entries are only read once written.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/ppmfe_back.sv =====
// ============================================================================
// PPM frame encoder back part
// Walks the head request through its intervals and drives the registered
// output channel, one interval per cycle unless stalled or out of requests.
// ============================================================================
module ppmfe_back import ppmfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_cmd              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TICK_W-1:0] o_interval_ticks,
    output logic              o_pin_level,
    output logic              o_frame_end
);

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_REM,
        PH_SYNC_END,
        PH_REST
    } t_phase;

    t_phase            r_phase, n_phase;
    logic              r_valid;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic              r_level, n_level;
    logic              r_end, n_end;
    logic              advance;
    logic              done;

    // Output register loads when empty or being drained and a request waits.
    assign advance = (!r_valid || i_ready) && !i_empty;
    assign o_pop   = advance && done;

    // Select the interval for the current phase.
    always_comb begin
        n_ticks = i_head.sync_ticks;
        n_level = !i_head.idle;
        n_end   = 1'b0;
        done    = 1'b0;
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC: begin
                n_phase = PH_REM;
            end
            PH_REM: begin
                n_ticks = i_head.rem_ticks;
                n_level = i_head.idle;
                done    = !i_head.last;
                n_phase = i_head.last ? PH_SYNC_END : PH_SYNC;
            end
            PH_SYNC_END: begin
                n_phase = PH_REST;
            end
            PH_REST: begin
                n_ticks = i_head.rest_ticks;
                n_level = i_head.idle;
                n_end   = 1'b1;
                done    = 1'b1;
                n_phase = PH_SYNC;
            end
            default: begin
                n_phase = PH_SYNC;
            end
        endcase
    end

    // Phase and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
                r_ticks <= n_ticks;
                r_level <= n_level;
                r_end   <= n_end;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_interval_ticks = r_ticks;
    assign o_pin_level      = r_level;
    assign o_frame_end      = r_end;

endmodule

// ===== design/ppm_frame_encoder_core.sv =====
// ============================================================================
// PPM frame encoder core
// Turns channel values into timed pin intervals of a PPM frame: a sync pulse
// and remainder per channel, then a closing sync pulse and the frame rest.
// ============================================================================
// Path: accepted request to the queue, then first interval to the output
// register; one interval per cycle unless stalled, two per channel, four
// for the closing one; a 4-entry queue takes back-to-back requests until full.
// Reset: synchronous; clears frame position, queue and output valid, and
// loads the register reset values (channel count 8, all others 0).
module ppm_frame_encoder_core import ppmfe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ppmfe_in_if.sink              i_in,
    ppmfe_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_range     <= 1'b0;
            r_cfg.sync_delay    <= '0;
            r_cfg.frame_extra   <= '0;
            r_cfg.channel_count <= COUNT_RESET;
            r_cfg.idle_level    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXT_RANGE:     r_cfg.ext_range     <= i_cfg_data[0];
                CFG_SYNC_DELAY:    r_cfg.sync_delay    <= i_cfg_data[3:0];
                CFG_FRAME_EXTRA:   r_cfg.frame_extra   <= i_cfg_data[3:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[4:0];
                CFG_IDLE_LEVEL:    r_cfg.idle_level    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front part: clamp and compute.
    ppmfe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_channel_value (i_in.channel_value),
        .i_queue_full    (full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Request queue.
    ppmfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    // Back part: interval sequencing and output register.
    ppmfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (head_cmd),
        .o_pop            (pop),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_interval_ticks (o_out.interval_ticks),
        .o_pin_level      (o_out.pin_level),
        .o_frame_end      (o_out.frame_end)
    );

endmodule
